FILE: rtl/core/hgun_pkg.sv
// Shared types and constants for the height-gradient unit-normal block.
`default_nettype none
package hgun_pkg;
  localparam int HEIGHT_BITS = 12;
  localparam int SUM_BITS    = 2 * HEIGHT_BITS + 2;      // dx^2 + dy^2 + one^2
  localparam int ROOT_BITS   = SUM_BITS / 2;              // length
  localparam int REM_BITS    = ROOT_BITS + 3;             // sqrt partial remainder
  localparam int FRAC_OUT    = 14;                        // Q1.14 output
  localparam int QUO_BITS    = FRAC_OUT + 1;              // quotient up to 16384
  localparam int DIV_BITS    = HEIGHT_BITS + FRAC_OUT + 1; // dividend and remainder
  localparam int SQ_STAGES   = ROOT_BITS;
  localparam int DV_STAGES   = QUO_BITS;
  localparam int BK_STAGES   = SQ_STAGES + DV_STAGES;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] height_below;
    logic [HEIGHT_BITS-1:0] height_above;
    logic [HEIGHT_BITS-1:0] height_right;
    logic [HEIGHT_BITS-1:0] height_left;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [14:0]        normal_z;
  } out_item_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic                   sx;
    logic                   sy;
    logic [HEIGHT_BITS-1:0] ax;
    logic [HEIGHT_BITS-1:0] ay;
    logic [SUM_BITS-1:0]    sumsq;
  } work_t;

  // One stage of the back pipeline
  typedef struct packed {
    logic                 v;
    logic                 sx;
    logic                 sy;
    logic [SUM_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
    logic [DIV_BITS-1:0]  rx;
    logic [DIV_BITS-1:0]  ry;
    logic [DIV_BITS-1:0]  rz;
    logic [QUO_BITS-1:0]  qx;
    logic [QUO_BITS-1:0]  qy;
    logic [QUO_BITS-1:0]  qz;
  } bk_stage_t;

  // Queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/hgun_front.sv
// Front part: takes items, forms differences, magnitudes and sum of squares.
`default_nettype none
module hgun_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire hgun_pkg::in_item_t in_item,
  input  wire logic               q_full,
  output logic                    q_push,
  output hgun_pkg::work_t         q_data
);
  localparam int HB = hgun_pkg::HEIGHT_BITS;
  localparam int SB = hgun_pkg::SUM_BITS;

  logic          s1_v_r, s2_v_r;
  logic          sx_r, sy_r;
  logic [HB-1:0] ax_r, ay_r;
  hgun_pkg::work_t w_r, w_nxt;
  logic          en;
  logic [HB:0]   dx, dy, nx, ny;

  // whole front advances unless its last stage is blocked
  assign en      = !(s2_v_r && q_full);
  assign in_full = !en;
  assign q_push  = s2_v_r && !q_full;
  assign q_data  = w_r;

  // differences and magnitudes
  always_comb begin
    dx = {1'b0, in_item.height_left}  - {1'b0, in_item.height_right};
    dy = {1'b0, in_item.height_below} - {1'b0, in_item.height_above};
    nx = -dx;
    ny = -dy;
  end

  // sum of squares, radius term one^2 added as a constant
  always_comb begin
    w_nxt.sx    = sx_r;
    w_nxt.sy    = sy_r;
    w_nxt.ax    = ax_r;
    w_nxt.ay    = ay_r;
    w_nxt.sumsq = SB'({{HB{1'b0}}, ax_r} * {{HB{1'b0}}, ax_r})
                + SB'({{HB{1'b0}}, ay_r} * {{HB{1'b0}}, ay_r})
                + (SB'(1) << (2 * HB));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_push;
      s2_v_r <= s1_v_r;
    end
    if (en) begin
      sx_r <= dx[HB];
      sy_r <= dy[HB];
      ax_r <= dx[HB] ? nx[HB-1:0] : dx[HB-1:0];
      ay_r <= dy[HB] ? ny[HB-1:0] : dy[HB-1:0];
      w_r  <= w_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/hgun_queue.sv
// Short queue between front and back.
`default_nettype none
module hgun_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire hgun_pkg::work_t wdata,
  input  wire logic            pop,
  output hgun_pkg::work_t      rdata,
  output hgun_pkg::q_stat_t    stat
);
  localparam int PB = hgun_pkg::QPTR_BITS;

  hgun_pkg::work_t mem_r [hgun_pkg::QDEPTH];
  logic [PB-1:0] wp_r, rp_r;
  logic [PB:0]   cnt_r;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == (PB+1)'(hgun_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PB+1)'(do_push) - (PB+1)'(do_pop);
    end
    if (do_push) mem_r[wp_r] <= wdata;
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PB+1)'(hgun_pkg::QDEPTH)) else $error("queue overfill");
  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count lost push");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> cnt_r == $past(cnt_r) - 1'b1) else $error("count lost pop");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r == PB'(rp_r + cnt_r[PB-1:0])) else $error("pointers and count disagree");
endmodule
`default_nettype wire

FILE: rtl/core/hgun_back.sv
// Back part: bit-per-stage square root, three bit-per-stage dividers, result queue.
`default_nettype none
module hgun_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire hgun_pkg::work_t q_data,
  input  wire logic            q_empty,
  output logic                 q_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output hgun_pkg::out_item_t  out_item
);
  localparam int NS = hgun_pkg::SQ_STAGES;
  localparam int NT = hgun_pkg::BK_STAGES;
  localparam int SB = hgun_pkg::SUM_BITS;
  localparam int RB = hgun_pkg::REM_BITS;
  localparam int LB = hgun_pkg::ROOT_BITS;
  localparam int DB = hgun_pkg::DIV_BITS;
  localparam int HB = hgun_pkg::HEIGHT_BITS;
  localparam int FB = hgun_pkg::FRAC_OUT;

  hgun_pkg::bk_stage_t pipe_r [NT];
  hgun_pkg::bk_stage_t pipe_nxt [NT];
  hgun_pkg::bk_stage_t head;
  hgun_pkg::out_item_t oq_r [2];
  hgun_pkg::out_item_t res;
  logic       wp_r, rp_r;
  logic [1:0] ocnt_r;
  logic       oq_full, en, opush, opop;

  assign oq_full   = (ocnt_r == 2'd2);
  assign out_empty = (ocnt_r == 2'd0);
  assign en        = !(pipe_r[NT-1].v && oq_full);
  assign q_pop     = en && !q_empty;
  assign opush     = en && pipe_r[NT-1].v;
  assign opop      = out_pop && !out_empty;
  assign out_item  = oq_r[rp_r];

  // stage zero entry: load radicand and dividends
  always_comb begin
    head      = '0;
    head.v    = !q_empty;
    head.sx   = q_data.sx;
    head.sy   = q_data.sy;
    head.rad  = q_data.sumsq;
    head.rx   = DB'({q_data.ax, {FB{1'b0}}});
    head.ry   = DB'({q_data.ay, {FB{1'b0}}});
    head.rz   = DB'(1) << (HB + FB);
  end

  // square root, two radicand bits per stage
  for (genvar j = 0; j < NS; j++) begin : g_sq
    logic [RB-1:0] rsh, trial;
    hgun_pkg::bk_stage_t src;
    always_comb begin
      src   = (j == 0) ? head : pipe_r[(j == 0) ? 0 : j-1];
      rsh   = {src.rem[RB-3:0], src.rad[SB-1-2*j -: 2]};
      trial = RB'({src.root, 2'b01});
      pipe_nxt[j] = src;
      if (rsh >= trial) begin
        pipe_nxt[j].rem  = rsh - trial;
        pipe_nxt[j].root = {src.root[LB-2:0], 1'b1};
      end else begin
        pipe_nxt[j].rem  = rsh;
        pipe_nxt[j].root = {src.root[LB-2:0], 1'b0};
      end
    end
  end

  // restoring division by the length, one quotient bit per stage
  for (genvar s = NS; s < NT; s++) begin : g_dv
    localparam int K = NT - 1 - s;
    logic [DB-1:0] d;
    hgun_pkg::bk_stage_t src;
    always_comb begin
      src = pipe_r[s-1];
      d   = DB'(src.root) << K;
      pipe_nxt[s] = src;
      if (src.rx >= d) begin
        pipe_nxt[s].rx    = src.rx - d;
        pipe_nxt[s].qx[K] = 1'b1;
      end
      if (src.ry >= d) begin
        pipe_nxt[s].ry    = src.ry - d;
        pipe_nxt[s].qy[K] = 1'b1;
      end
      if (src.rz >= d) begin
        pipe_nxt[s].rz    = src.rz - d;
        pipe_nxt[s].qz[K] = 1'b1;
      end
    end
  end

  // apply signs
  always_comb begin
    res.normal_x = pipe_r[NT-1].sx ? -$signed({1'b0, pipe_r[NT-1].qx})
                                   :  $signed({1'b0, pipe_r[NT-1].qx});
    res.normal_y = pipe_r[NT-1].sy ? -$signed({1'b0, pipe_r[NT-1].qy})
                                   :  $signed({1'b0, pipe_r[NT-1].qy});
    res.normal_z = pipe_r[NT-1].qz;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NT; i++) begin
      if (!rst_n) pipe_r[i].v <= 1'b0;
      else if (en) pipe_r[i] <= pipe_nxt[i];
    end
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (opush) wp_r <= !wp_r;
      if (opop)  rp_r <= !rp_r;
      ocnt_r <= ocnt_r + 2'(opush) - 2'(opop);
    end
    if (opush) oq_r[wp_r] <= res;
  end
endmodule
`default_nettype wire

FILE: rtl/core/height_gradient_unit_normal.sv
// Top level: unit normal from four neighbor heights by central difference.
// Path from push to the result: 2 front stages, queue, 13 square-root stages,
//   15 divider stages and the result queue; stalls can hold items on the way.
// Throughput: one item per cycle while the result queue is popped, set by the fully pipelined root and dividers.
// Reset (rst_n low, synchronous) empties the queues and pipeline valid bits.
`default_nettype none
module height_gradient_unit_normal (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire hgun_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output hgun_pkg::out_item_t      out_item
);
  logic              q_push, q_pop;
  hgun_pkg::work_t   q_wdata, q_rdata;
  hgun_pkg::q_stat_t q_stat;

  hgun_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .q_full(q_stat.full), .q_push, .q_data(q_wdata)
  );

  hgun_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata),
    .pop(q_pop), .rdata(q_rdata), .stat(q_stat)
  );

  hgun_back u_back (
    .clk, .rst_n, .q_data(q_rdata), .q_empty(q_stat.empty), .q_pop,
    .out_empty, .out_pop, .out_item
  );
endmodule
`default_nettype wire
